// ----- rtl/decision_tree_inference_macros.svh -----
// ----------------------------------------------------------------------------
// Decision tree inference: assertion macros
// Shared forms for the concurrent checks of the tree walker.
// ----------------------------------------------------------------------------
`ifndef DECISION_TREE_INFERENCE_MACROS_SVH
`define DECISION_TREE_INFERENCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/dti_pkg.sv -----
// ----------------------------------------------------------------------------
// Decision tree inference: package
// Request codes, payload layouts and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dti_pkg;

	// Request kinds carried on the input tuser.
	localparam logic [1:0] ACT_NODE     = 2'd0;
	localparam logic [1:0] ACT_SAMPLE   = 2'd1;
	localparam logic [1:0] ACT_CLASSIFY = 2'd2;

	localparam int ACT_W   = 2;
	localparam int IN_DW   = 96;
	localparam int OUT_DW  = 32;

	// One half in signed Q16.16.
	localparam logic signed [31:0] HALF_Q16 = 32'sh0000_8000;

	// Input tdata, first field in the lowest bits (packed structs list MSB first).
	typedef struct packed {
		logic               pad;
		logic [7:0]         right_child;
		logic [7:0]         left_child;
		logic signed [31:0] node_number;
		logic [5:0]         split_feature;
		logic               leaf_flag;
		logic signed [31:0] sample_value;
		logic [7:0]         slot;
	} in_item_t;

	// One stored tree node.
	typedef struct packed {
		logic               leaf;
		logic [5:0]         feature;
		logic signed [31:0] value;
		logic [7:0]         left;
		logic [7:0]         right;
	} node_t;

	localparam int NODE_W = $bits(node_t);

endpackage

`default_nettype wire

// ----- rtl/dti_mem.sv -----
// ----------------------------------------------------------------------------
// Decision tree inference: synchronous memory
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module dti_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 55,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next enabled read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/decision_tree_inference.sv -----
// ----------------------------------------------------------------------------
// Decision tree inference: top level
// Loads a binary decision tree and one sample into memories and walks the
// tree from node 0 to a leaf, or to a depth or child-index error, for each classify request.
// ----------------------------------------------------------------------------
// Channel  Dir  Content
// s_axis   in   tuser: action; tdata: node or sample write fields
// m_axis   out  tdata: prediction; tuser: depth_error
// cfg      in   cfg_data: class_mode
//
// A classify request passes S_NODE then S_FEAT on each internal node (node
// memory read, then sample memory read and compare), S_NODE on a leaf and
// S_EMIT to load the output register.
// A new request is taken only while no walk is in progress. A stalled result
// holds in the output register; a finished walk waits until it is free.
// Reset clears control state only; both memories are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decision_tree_inference_macros.svh"

module decision_tree_inference #(
	parameter int NODE_COUNT    = 256,
	parameter int FEATURE_COUNT = 64,
	parameter int DEPTH_LIMIT   = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_axis_tvalid,
	output logic                           s_axis_tready,
	// slot[7:0], sample_value[39:8], leaf_flag[40], split_feature[46:41],
	// node_number[78:47], left_child[86:79], right_child[94:87], zero pad[95]
	input  wire logic [dti_pkg::IN_DW-1:0] s_axis_tdata,
	// action[1:0]
	input  wire logic [dti_pkg::ACT_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	// prediction[31:0]
	output logic [dti_pkg::OUT_DW-1:0]     m_axis_tdata,
	// depth_error[0]
	output logic                           m_axis_tuser,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic                      cfg_data
);

	import dti_pkg::*;

	localparam int NAW = $clog2(NODE_COUNT);
	localparam int FAW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
	localparam int LVW = $clog2(DEPTH_LIMIT + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_NODE,
		S_FEAT,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic [LVW-1:0]     level_q;
	logic               feat_ok_q;
	logic signed [31:0] res_q;
	logic               err_q;
	logic               out_valid_q;
	logic [OUT_DW-1:0]  out_data_q;
	logic               out_err_q;
	logic               class_mode_q;

	in_item_t           item;
	logic               in_acc;
	logic [31:0]        slot_ext;
	logic               node_we;
	logic               samp_we;
	logic               start;
	logic [NODE_W-1:0]  node_rdata;
	node_t              node_rd;
	logic               node_re;
	logic [NAW-1:0]     node_raddr;
	logic [31:0]        feat_ext;
	logic               feat_ok;
	logic               samp_re;
	logic [31:0]        samp_rdata;
	logic signed [31:0] feat_val;
	logic [7:0]         next_idx;
	logic [31:0]        next_ext;
	logic               next_ok;
	logic               depth_hit;
	logic               out_free;
	logic signed [31:0] leaf_res;

	// Configuration register; always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			class_mode_q <= cfg_data;
		end
	end

	// Input request decode and memory write enables.
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign item          = in_item_t'(s_axis_tdata);
	assign slot_ext      = 32'(item.slot);
	assign node_we       = in_acc && (s_axis_tuser == ACT_NODE) && (slot_ext < NODE_COUNT);
	assign samp_we       = in_acc && (s_axis_tuser == ACT_SAMPLE) &&
		(slot_ext < FEATURE_COUNT);
	assign start         = in_acc && (s_axis_tuser == ACT_CLASSIFY);

	// Walk step logic: feature lookup, compare and child selection.
	always_comb begin
		node_rd   = node_t'(node_rdata);
		feat_ext  = 32'(node_rd.feature);
		feat_ok   = feat_ext < FEATURE_COUNT;
		samp_re   = (state_q == S_NODE) && !node_rd.leaf;
		feat_val  = feat_ok_q ? $signed(samp_rdata) : 32'sd0;
		next_idx  = (feat_val < node_rd.value) ? node_rd.left : node_rd.right;
		next_ext  = 32'(next_idx);
		next_ok   = next_ext < NODE_COUNT;
		depth_hit = (level_q == LVW'(DEPTH_LIMIT));
		node_re   = start || ((state_q == S_FEAT) && !depth_hit && next_ok);
		node_raddr = (state_q == S_FEAT) ? next_ext[NAW-1:0] : '0;
		if (class_mode_q) begin
			leaf_res = (node_rd.value >= HALF_Q16) ? 32'sd1 : 32'sd0;
		end else begin
			leaf_res = node_rd.value;
		end
		out_free = !out_valid_q || m_axis_tready;
	end

	// Node and sample memories.
	dti_mem #(
		.DEPTH (NODE_COUNT),
		.WIDTH (NODE_W)
	) u_node_mem (
		.clk   (clk),
		.we    (node_we),
		.waddr (slot_ext[NAW-1:0]),
		.wdata ({item.leaf_flag, item.split_feature, item.node_number,
			item.left_child, item.right_child}),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	dti_mem #(
		.DEPTH (FEATURE_COUNT),
		.WIDTH (32)
	) u_samp_mem (
		.clk   (clk),
		.we    (samp_we),
		.waddr (slot_ext[FAW-1:0]),
		.wdata (item.sample_value),
		.re    (samp_re),
		.raddr (feat_ext[FAW-1:0]),
		.rdata (samp_rdata)
	);

	// Walk sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			level_q     <= '0;
			feat_ok_q   <= 1'b0;
			res_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_err_q   <= 1'b0;
		end else begin
			// The output register loads a finished walk or empties on a taken result.
			if ((state_q == S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						level_q <= LVW'(1);
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					if (node_rd.leaf) begin
						res_q   <= leaf_res;
						err_q   <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						feat_ok_q <= feat_ok;
						state_q   <= S_FEAT;
					end
				end
				S_FEAT: begin
					if (depth_hit || !next_ok) begin
						res_q   <= '0;
						err_q   <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						level_q <= level_q + LVW'(1);
						state_q <= S_NODE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_data_q  <= res_q;
						out_err_q   <= err_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_err_q;

	// Checks on the walker.
	`DTI_ASSERT_NEXT(a_start_walk, clk, arst_n, start,
		(state_q == S_NODE) && (level_q == LVW'(1)),
		"classify request did not start a walk at node 0")
	`DTI_ASSERT_NOW(a_level_range, clk, arst_n, (state_q == S_NODE) || (state_q == S_FEAT),
		(level_q != '0) && (level_q <= LVW'(DEPTH_LIMIT)),
		"walk level outside the depth limit")
	`DTI_ASSERT_NOW(a_err_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata == '0, "depth error result carries a nonzero prediction")
	`DTI_ASSERT_NEXT(a_emit_load, clk, arst_n, (state_q == S_EMIT) && out_free,
		m_axis_tvalid && (state_q == S_IDLE), "finished walk did not load the output")

endmodule

`default_nettype wire
